@@ sv/utf8sdv_pkg.sv @@
// Shared types and constants for the UTF-8 stream decoder and validator.
// Used by utf8sdv_step, utf8sdv_out_buf, the top level and the testbench.
package utf8sdv_pkg;

    localparam int unsigned CP_W  = 21;
    localparam int unsigned LEN_W = 3;

    // Byte classification masks and patterns.
    localparam logic [7:0] MASK_C0 = 8'hC0;
    localparam logic [7:0] MASK_E0 = 8'hE0;
    localparam logic [7:0] MASK_F0 = 8'hF0;
    localparam logic [7:0] MASK_F8 = 8'hF8;
    localparam logic [7:0] CONT_PAT  = 8'h80;
    localparam logic [7:0] LEAD2_PAT = 8'hC0;
    localparam logic [7:0] LEAD3_PAT = 8'hE0;
    localparam logic [7:0] LEAD4_PAT = 8'hF0;

    // Sequence lengths.
    localparam logic [LEN_W-1:0] LEN_1 = 3'd1;
    localparam logic [LEN_W-1:0] LEN_2 = 3'd2;
    localparam logic [LEN_W-1:0] LEN_3 = 3'd3;
    localparam logic [LEN_W-1:0] LEN_4 = 3'd4;

    // Scalar value limits.
    localparam logic [CP_W-1:0] MIN_2     = 21'h000080;
    localparam logic [CP_W-1:0] MIN_3     = 21'h000800;
    localparam logic [CP_W-1:0] MIN_4     = 21'h010000;
    localparam logic [CP_W-1:0] SURR_LO   = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI   = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;

    typedef struct packed {
        logic [CP_W-1:0]  partial_value;
        logic [1:0]       bytes_due;
        logic [LEN_W-1:0] sequence_size;
        logic             rejecting;
    } dec_state_t;

    typedef struct packed {
        logic             emit;
        logic [CP_W-1:0]  code_point;
        logic [LEN_W-1:0] seq_length;
        logic             point_ready;
        logic             decode_error;
        logic             string_done;
        logic             string_valid;
    } dec_result_t;

    // True when a completed value is neither overlong, a surrogate, nor out of range.
    function automatic logic complete_ok(logic [CP_W-1:0] c, logic [LEN_W-1:0] size);
        logic ok;
        ok = 1'b1;
        if (size == LEN_2 && c < MIN_2) ok = 1'b0;
        if (size == LEN_3 && c < MIN_3) ok = 1'b0;
        if (size == LEN_4 && c < MIN_4) ok = 1'b0;
        if (c >= SURR_LO && c <= SURR_HI) ok = 1'b0;
        if (c > CP_MAX) ok = 1'b0;
        return ok;
    endfunction

endpackage

@@ sv/utf8sdv_step.sv @@
// Combinational decode of one byte against the current sequence state.
// Depends on utf8sdv_pkg for the state and result types and constants.
module utf8sdv_step (
    input  utf8sdv_pkg::dec_state_t  state_in,
    input  logic [7:0]               in_byte,
    input  logic                     string_last,
    output utf8sdv_pkg::dec_state_t  state_out,
    output utf8sdv_pkg::dec_result_t result
);

    always_comb begin
        utf8sdv_pkg::dec_state_t ns;
        logic [utf8sdv_pkg::CP_W-1:0]  acc;
        logic [utf8sdv_pkg::CP_W-1:0]  cp;
        logic [utf8sdv_pkg::LEN_W-1:0] len;
        logic err;
        logic rdy;

        ns  = state_in;
        acc = {state_in.partial_value[utf8sdv_pkg::CP_W-7:0], in_byte[5:0]};
        cp  = '0;
        len = '0;
        err = 1'b0;
        rdy = 1'b0;

        if (!state_in.rejecting) begin
            if (state_in.bytes_due == 2'd0) begin
                if (!in_byte[7]) begin
                    rdy = 1'b1;
                    cp  = {13'd0, in_byte};
                    len = utf8sdv_pkg::LEN_1;
                end else if ((in_byte & utf8sdv_pkg::MASK_E0) == utf8sdv_pkg::LEAD2_PAT) begin
                    ns.partial_value = {16'd0, in_byte[4:0]};
                    ns.sequence_size = utf8sdv_pkg::LEN_2;
                    ns.bytes_due     = 2'd1;
                end else if ((in_byte & utf8sdv_pkg::MASK_F0) == utf8sdv_pkg::LEAD3_PAT) begin
                    ns.partial_value = {17'd0, in_byte[3:0]};
                    ns.sequence_size = utf8sdv_pkg::LEN_3;
                    ns.bytes_due     = 2'd2;
                end else if ((in_byte & utf8sdv_pkg::MASK_F8) == utf8sdv_pkg::LEAD4_PAT) begin
                    ns.partial_value = {18'd0, in_byte[2:0]};
                    ns.sequence_size = utf8sdv_pkg::LEN_4;
                    ns.bytes_due     = 2'd3;
                end else begin
                    err = 1'b1;
                end
            end else if ((in_byte & utf8sdv_pkg::MASK_C0) != utf8sdv_pkg::CONT_PAT) begin
                err = 1'b1;
            end else begin
                ns.partial_value = acc;
                ns.bytes_due     = state_in.bytes_due - 2'd1;
                // Final continuation byte: run the overlong, surrogate and range checks.
                if (state_in.bytes_due == 2'd1) begin
                    if (utf8sdv_pkg::complete_ok(acc, state_in.sequence_size)) begin
                        rdy = 1'b1;
                        cp  = acc;
                        len = state_in.sequence_size;
                        ns.partial_value = '0;
                        ns.sequence_size = '0;
                    end else begin
                        err = 1'b1;
                    end
                end
            end
            if (err) begin
                ns = '0;
                ns.rejecting = 1'b1;
            end
        end

        // A sequence still open on the last byte is cut off.
        if (string_last && !ns.rejecting && ns.bytes_due != 2'd0) begin
            err = 1'b1;
            ns  = '0;
            ns.rejecting = 1'b1;
        end

        result.emit         = rdy || err || string_last;
        result.code_point   = cp;
        result.seq_length   = len;
        result.point_ready  = rdy;
        result.decode_error = err;
        result.string_done  = string_last;
        result.string_valid = string_last && !ns.rejecting;

        // The end of a string returns the decoder to its reset state.
        state_out = string_last ? '0 : ns;
    end

endmodule

@@ sv/utf8sdv_out_buf.sv @@
// Result register with valid/ready handshake toward the consumer.
// Depends on utf8sdv_pkg for the result type.
module utf8sdv_out_buf (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      load,
    input  utf8sdv_pkg::dec_result_t  result,
    input  logic                      m_ready,
    output logic                      m_valid,
    output logic                      space,
    output utf8sdv_pkg::dec_result_t  held
);

    logic                     valid_reg;
    logic                     valid_next;
    utf8sdv_pkg::dec_result_t data_reg;

    // The register can take a new request whenever it is empty or being drained.
    assign space   = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign held    = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

endmodule

@@ sv/utf8_stream_decoder_validator.sv @@
// UTF-8 stream decoder and validator, one byte per cycle while the result register has space.
// The result of an accepted byte is registered and appears on m_ in the cycle after the byte is accepted.
// The result register drains while the next byte enters, so bytes are not held up while m_ready stays high.
// Reset (aresetn low, synchronous) clears the sequence state and empties the result register.
// Depends on utf8sdv_pkg, utf8sdv_step and utf8sdv_out_buf.
module utf8_stream_decoder_validator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_string_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [20:0] m_code_point,
    output logic [2:0]  m_seq_length,
    output logic        m_point_ready,
    output logic        m_decode_error,
    output logic        m_string_done,
    output logic        m_string_valid
);

    utf8sdv_pkg::dec_state_t  state_reg;
    utf8sdv_pkg::dec_state_t  state_next;
    utf8sdv_pkg::dec_result_t step_res;
    utf8sdv_pkg::dec_result_t held;
    logic                     accept;
    logic                     space;

    assign s_ready = space;
    assign accept  = s_valid && space;

    utf8sdv_step u_step (
        .state_in    (state_reg),
        .in_byte     (s_in_byte),
        .string_last (s_string_last),
        .state_out   (state_next),
        .result      (step_res)
    );

    utf8sdv_out_buf u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (accept && step_res.emit),
        .result  (step_res),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .space   (space),
        .held    (held)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    assign m_code_point   = held.code_point;
    assign m_seq_length   = held.seq_length;
    assign m_point_ready  = held.point_ready;
    assign m_decode_error = held.decode_error;
    assign m_string_done  = held.string_done;
    assign m_string_valid = held.string_valid;

endmodule

@@ sv/utf8sdv_checker.sv @@
// Port-level checks for the UTF-8 stream decoder and validator.
// Depends on nothing but the top level's ports; bound to the top level below.
module utf8sdv_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [20:0] m_code_point,
    input logic [2:0]  m_seq_length,
    input logic        m_point_ready,
    input logic        m_decode_error,
    input logic        m_string_done,
    input logic        m_string_valid
);

    // A completed code point carries a legal length and a scalar in range.
    a_point_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_point_ready |->
            (m_seq_length == 3'd1 || m_seq_length == 3'd2 ||
             m_seq_length == 3'd3 || m_seq_length == 3'd4) &&
            m_code_point <= 21'h10FFFF && !m_decode_error)
        else $error("bad completed code point");

    // Without a code point the value and length fields read as zero.
    a_idle_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_point_ready |-> m_code_point == 21'd0 && m_seq_length == 3'd0)
        else $error("stale code point fields");

    // A valid verdict only closes a string and never coincides with an error.
    a_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_string_valid |-> m_string_done && !m_decode_error)
        else $error("inconsistent string verdict");

    // A stalled request keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_code_point) &&
            $stable(m_decode_error) && $stable(m_string_done))
        else $error("result changed while stalled");

endmodule

bind utf8_stream_decoder_validator utf8sdv_checker u_utf8sdv_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_code_point   (m_code_point),
    .m_seq_length   (m_seq_length),
    .m_point_ready  (m_point_ready),
    .m_decode_error (m_decode_error),
    .m_string_done  (m_string_done),
    .m_string_valid (m_string_valid)
);

@@ tb/sv/tb_utf8_stream_decoder_validator.sv @@
// Self-checking testbench for utf8_stream_decoder_validator: byte strings, directed and random,
// are decoded by an in-bench UTF-8 decoder and compared against every result the block returns.
// Depends on utf8sdv_pkg and the utf8_stream_decoder_validator RTL.
module tb_utf8_stream_decoder_validator;

    localparam int RANDOM_BYTES = 1400;
    localparam int CYCLE_LIMIT  = 400000;

    typedef logic [utf8sdv_pkg::CP_W-1:0] cp_t;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } byte_req_t;

    typedef struct packed {
        logic [utf8sdv_pkg::CP_W-1:0]  cp;
        logic [utf8sdv_pkg::LEN_W-1:0] len;
        logic                          rdy;
        logic                          err;
        logic                          done;
        logic                          ok;
    } utf8_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = 8'h00;
    logic        s_string_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [20:0] m_code_point;
    logic [2:0]  m_seq_length;
    logic        m_point_ready;
    logic        m_decode_error;
    logic        m_string_done;
    logic        m_string_valid;

    byte_req_t    pending_bytes[$];
    utf8_result_t expected_chars[$];
    int           mismatches = 0;
    int           cycle_count = 0;
    int           burst_left = 0;
    int           gap_left = 0;
    int           stall_mode = 0;

    // Decoder state mirrored in the bench.
    logic [utf8sdv_pkg::CP_W-1:0]  acc_bits;
    logic [1:0]                    cont_left;
    logic [utf8sdv_pkg::LEN_W-1:0] seq_len;
    logic                          flushing;

    utf8_stream_decoder_validator dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_string_last (s_string_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_code_point  (m_code_point),
        .m_seq_length  (m_seq_length),
        .m_point_ready (m_point_ready),
        .m_decode_error(m_decode_error),
        .m_string_done (m_string_done),
        .m_string_valid(m_string_valid)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic void clear_partial();
        acc_bits  = '0;
        cont_left = '0;
        seq_len   = '0;
    endfunction

    // Returns 1 when the byte produces a result, which is written to r.
    function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                       output utf8_result_t r);
        logic [utf8sdv_pkg::CP_W-1:0] floor_val;
        bit                           bad;
        r   = '0;
        bad = 1'b0;
        if (!flushing) begin
            if (cont_left == 2'd0) begin
                if (b < utf8sdv_pkg::CONT_PAT) begin
                    r.rdy = 1'b1;
                    r.cp  = {13'd0, b};
                    r.len = utf8sdv_pkg::LEN_1;
                end else if ((b & utf8sdv_pkg::MASK_E0) == utf8sdv_pkg::LEAD2_PAT) begin
                    acc_bits  = {16'd0, b[4:0]};
                    seq_len   = utf8sdv_pkg::LEN_2;
                    cont_left = 2'd1;
                end else if ((b & utf8sdv_pkg::MASK_F0) == utf8sdv_pkg::LEAD3_PAT) begin
                    acc_bits  = {17'd0, b[3:0]};
                    seq_len   = utf8sdv_pkg::LEN_3;
                    cont_left = 2'd2;
                end else if ((b & utf8sdv_pkg::MASK_F8) == utf8sdv_pkg::LEAD4_PAT) begin
                    acc_bits  = {18'd0, b[2:0]};
                    seq_len   = utf8sdv_pkg::LEN_4;
                    cont_left = 2'd3;
                end else begin
                    bad = 1'b1;
                end
            end else if ((b & utf8sdv_pkg::MASK_C0) != utf8sdv_pkg::CONT_PAT) begin
                bad = 1'b1;
            end else begin
                acc_bits  = {acc_bits[utf8sdv_pkg::CP_W-7:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0) begin
                    case (seq_len)
                        utf8sdv_pkg::LEN_2: floor_val = utf8sdv_pkg::MIN_2;
                        utf8sdv_pkg::LEN_3: floor_val = utf8sdv_pkg::MIN_3;
                        default:            floor_val = utf8sdv_pkg::MIN_4;
                    endcase
                    if (acc_bits < floor_val || acc_bits > utf8sdv_pkg::CP_MAX ||
                        (acc_bits >= utf8sdv_pkg::SURR_LO &&
                         acc_bits <= utf8sdv_pkg::SURR_HI)) begin
                        bad = 1'b1;
                    end else begin
                        r.rdy = 1'b1;
                        r.cp  = acc_bits;
                        r.len = seq_len;
                        clear_partial();
                    end
                end
            end
            if (bad) begin
                flushing = 1'b1;
                clear_partial();
            end
        end
        // A string that ends inside a sequence is cut off.
        if (last && !flushing && cont_left != 2'd0) begin
            bad      = 1'b1;
            flushing = 1'b1;
            clear_partial();
        end
        r.err = bad;
        if (last) begin
            r.done = 1'b1;
            r.ok   = !flushing;
            flushing = 1'b0;
            clear_partial();
        end
        return r.rdy || r.err || r.done;
    endfunction

    function automatic void queue_byte(input logic [7:0] b, input logic last);
        pending_bytes.push_back({b, last});
    endfunction

    // Encodes cp in n bytes; a longer n than needed gives an overlong form.
    function automatic void queue_char(input logic [utf8sdv_pkg::CP_W-1:0] cp, input int n);
        case (n)
            1: queue_byte(cp[7:0], 1'b0);
            2: begin
                queue_byte(utf8sdv_pkg::LEAD2_PAT | cp[10:6], 1'b0);
                queue_byte(utf8sdv_pkg::CONT_PAT | cp[5:0], 1'b0);
            end
            3: begin
                queue_byte(utf8sdv_pkg::LEAD3_PAT | cp[15:12], 1'b0);
                queue_byte(utf8sdv_pkg::CONT_PAT | cp[11:6], 1'b0);
                queue_byte(utf8sdv_pkg::CONT_PAT | cp[5:0], 1'b0);
            end
            default: begin
                queue_byte(utf8sdv_pkg::LEAD4_PAT | cp[20:18], 1'b0);
                queue_byte(utf8sdv_pkg::CONT_PAT | cp[17:12], 1'b0);
                queue_byte(utf8sdv_pkg::CONT_PAT | cp[11:6], 1'b0);
                queue_byte(utf8sdv_pkg::CONT_PAT | cp[5:0], 1'b0);
            end
        endcase
    endfunction

    function automatic logic [utf8sdv_pkg::CP_W-1:0] legal_value(input int n);
        logic [utf8sdv_pkg::CP_W-1:0] cp;
        case (n)
            1: cp = cp_t'($urandom_range(0, 'h7F));
            2: cp = cp_t'($urandom_range('h80, 'h7FF));
            3: begin
                cp = cp_t'($urandom_range('h800, 'hFFFF));
                if (cp >= utf8sdv_pkg::SURR_LO && cp <= utf8sdv_pkg::SURR_HI) begin
                    cp = cp ^ 21'h002000;
                end
            end
            default: cp = cp_t'($urandom_range('h10000, 'h10FFFF));
        endcase
        return cp;
    endfunction

    // Mostly well-formed text, with noise, malformed and truncated sequences mixed in.
    function automatic void queue_random_string();
        int n_chars;
        int pick;
        int n;
        n_chars = $urandom_range(1, 10);
        for (int i = 0; i < n_chars; i++) begin
            pick = $urandom_range(0, 99);
            n    = $urandom_range(1, 4);
            if (pick < 80) begin
                queue_char(legal_value(n), n);
            end else if (pick < 85) begin
                queue_byte(8'($urandom_range(0, 255)), 1'b0);
            end else if (pick < 89) begin
                n = $urandom_range(2, 4);
                queue_char(legal_value(n - 1), n);
            end else if (pick < 92) begin
                queue_char(cp_t'($urandom_range(utf8sdv_pkg::SURR_LO, utf8sdv_pkg::SURR_HI)), 3);
            end else if (pick < 95) begin
                queue_char(cp_t'($urandom_range('h110000, 'h1FFFFF)), 4);
            end else begin
                n = $urandom_range(2, 4);
                queue_char(legal_value(n), n);
                repeat ($urandom_range(1, n - 1)) void'(pending_bytes.pop_back());
            end
        end
        pending_bytes[pending_bytes.size() - 1].last = 1'b1;
    endfunction

    initial begin
        // Zero byte, extremes of the one-, two-, three- and four-byte forms.
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h7F, 1'b0);
        queue_char(utf8sdv_pkg::MIN_2, 2);
        queue_char(21'h00FFFF, 3);
        queue_char(utf8sdv_pkg::CP_MAX, 4);
        pending_bytes[pending_bytes.size() - 1].last = 1'b1;
        // Overlong form, then bytes dropped until the string ends.
        queue_byte(8'hC0, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h41, 1'b1);
        // Surrogate, flagged on the last byte.
        queue_char(utf8sdv_pkg::SURR_LO, 3);
        pending_bytes[pending_bytes.size() - 1].last = 1'b1;
        // Value above the Unicode range.
        queue_char(utf8sdv_pkg::CP_MAX + 21'd1, 4);
        pending_bytes[pending_bytes.size() - 1].last = 1'b1;
        // Invalid lead byte as the last byte.
        queue_byte(8'hFF, 1'b1);
        // Bad continuation byte.
        queue_byte(8'hC3, 1'b0);
        queue_byte(8'h41, 1'b1);
        // Sequence cut off by the end of the string.
        queue_byte(8'hE2, 1'b0);
        queue_byte(8'h82, 1'b1);
        while (pending_bytes.size() < RANDOM_BYTES + 26) queue_random_string();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_bytes.size() != 0 || s_valid) @(posedge aclk);
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && expected_chars.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Request driver: bursts of random length separated by random gaps.
    always @(posedge aclk) begin
        byte_req_t req;
        if (!aresetn) begin
            s_valid       <= 1'b0;
            s_in_byte     <= 8'h00;
            s_string_last <= 1'b0;
            burst_left    <= 0;
            gap_left      <= 0;
        end else if (!s_valid || s_ready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid  <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                req = pending_bytes.pop_front();
                s_in_byte     <= req.b;
                s_string_last <= req.last;
                s_valid       <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    // Sender gaps are off whenever bit 12 of cycle_count is set.
                    if (cycle_count[12] || $urandom_range(0, 3) == 0) gap_left <= 0;
                    else gap_left <= $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver backpressure; the pattern is re-chosen whenever the low byte of cycle_count is zero.
    always @(posedge aclk) begin
        if (cycle_count[7:0] == 8'd0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 1) != 0);
            2:       m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (cycle_count[3:0] == 4'd0);
        endcase
    end

    // Monitor: predict on each accepted request, then check each accepted result.
    always @(posedge aclk) begin
        utf8_result_t want;
        utf8_result_t got;
        if (!aresetn) begin
            flushing = 1'b0;
            clear_partial();
        end else begin
            if (s_valid && s_ready) begin
                if (decode_byte(s_in_byte, s_string_last, want)) expected_chars.push_back(want);
            end
            if (m_valid && m_ready) begin
                got = {m_code_point, m_seq_length, m_point_ready, m_decode_error,
                       m_string_done, m_string_valid};
                if (expected_chars.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result: cp=%h len=%0d rdy=%b err=%b done=%b ok=%b",
                                 got.cp, got.len, got.rdy, got.err, got.done, got.ok);
                    mismatches++;
                end else begin
                    want = expected_chars.pop_front();
                    if (got.cp != want.cp || got.len != want.len || got.rdy != want.rdy ||
                        got.err != want.err || got.done != want.done || got.ok != want.ok) begin
                        if (mismatches < 10) begin
                            $write("mismatch: exp cp=%h len=%0d rdy=%b err=%b done=%b ok=%b",
                                   want.cp, want.len, want.rdy, want.err, want.done, want.ok);
                            $display(" | got cp=%h len=%0d rdy=%b err=%b done=%b ok=%b",
                                     got.cp, got.len, got.rdy, got.err, got.done, got.ok);
                        end
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

endmodule
